// ===== hdl/bcsd_pkg.sv =====
package bcsd_pkg;

	localparam int FIELD_W = 24;
	localparam int SLOT_W  = 16;
	localparam int DMG_W   = 16;
	localparam int SQ_W    = 48;
	localparam int LEN_W   = 24;
	localparam int CS_W    = 24;
	localparam int TC_W    = 32;
	localparam int K_W     = 57;
	localparam int K_LO_W  = 28;
	localparam int PROD_W  = 82;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [1:0] REG_CRIT_STRETCH = 2'd0;
	localparam logic [1:0] REG_THERM_EN     = 2'd1;
	localparam logic [1:0] REG_THERM_COEF   = 2'd2;

	typedef struct packed {
		logic load;
		logic step;
	} sqrt_ctl_t;

endpackage

// ===== hdl/bcsd_if.sv =====
interface bcsd_bond_if;
	logic valid;
	logic ready;
	logic signed [bcsd_pkg::FIELD_W-1:0] ref_dx;
	logic signed [bcsd_pkg::FIELD_W-1:0] ref_dy;
	logic signed [bcsd_pkg::FIELD_W-1:0] ref_dz;
	logic signed [bcsd_pkg::FIELD_W-1:0] cur_dx;
	logic signed [bcsd_pkg::FIELD_W-1:0] cur_dy;
	logic signed [bcsd_pkg::FIELD_W-1:0] cur_dz;
	logic signed [bcsd_pkg::FIELD_W-1:0] temp_change;
	logic [bcsd_pkg::SLOT_W-1:0] bond_slot;
	logic node_last;
	logic node_empty;
	modport source(output valid, ref_dx, ref_dy, ref_dz, cur_dx, cur_dy, cur_dz,
		temp_change, bond_slot, node_last, node_empty, input ready);
	modport sink(input valid, ref_dx, ref_dy, ref_dz, cur_dx, cur_dy, cur_dz,
		temp_change, bond_slot, node_last, node_empty, output ready);
endinterface

interface bcsd_res_if;
	logic valid;
	logic ready;
	logic bond_broken;
	logic newly_broken;
	logic node_done;
	logic [bcsd_pkg::DMG_W-1:0] node_damage;
	modport source(output valid, bond_broken, newly_broken, node_done, node_damage,
		input ready);
	modport sink(input valid, bond_broken, newly_broken, node_done, node_damage,
		output ready);
endinterface

// ===== hdl/bcsd_ram.sv =====
module bcsd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/bcsd_sqrt.sv =====
module bcsd_sqrt import bcsd_pkg::*; (
	input  logic             clk,
	input  sqrt_ctl_t        ctl,
	input  logic [SQ_W-1:0]  radicand,
	output logic [LEN_W-1:0] root
);
	logic [SQ_W-1:0]    rad_q;
	logic [LEN_W+1:0]   rem_q;
	logic [LEN_W-1:0]   root_q;
	logic [LEN_W+3:0]   r;
	logic [LEN_W+3:0]   trial;

	// one result bit per step, two radicand bits consumed
	always_comb begin
		r     = {rem_q, rad_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.step) begin
			rad_q <= {rad_q[SQ_W-3:0], 2'b00};
			if (r >= trial) begin
				rem_q  <= (LEN_W+2)'(r - trial);
				root_q <= {root_q[LEN_W-2:0], 1'b1};
			end else begin
				rem_q  <= r[LEN_W+1:0];
				root_q <= {root_q[LEN_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

// ===== hdl/bond_critical_stretch_damage_unit.sv =====
// channel   | dir | payload                                   | accepted when
// bond_in   | in  | ref/cur vectors, temp_change, slot, flags | valid & ready
// result    | out | bond_broken, newly_broken, node_done/dmg  | valid & ready
// apb       | in  | critical_stretch, thermal_enable/coef      | psel&penable&pwrite
//
// A bond goes through squaring on one 24x24 multiplier per vector, 24 steps of
// the bit-serial square roots, partial-product states MUL0/MUL1 for the
// breaking threshold, a compare/update and an output state; bond_in.ready
// returns once the result is in the output register. A node's last bond also
// goes through the restoring damage divider; an empty node goes straight to
// the output state. After reset the damage store is cleared one entry per
// cycle (min(MAX_BONDS,65536) entries) while bond_in.ready stays low. A stalled
// result is held in the output register; the next bond may enter meanwhile.
module bond_critical_stretch_damage_unit import bcsd_pkg::*; #(
	parameter int MAX_BONDS     = 65536,
	parameter int MAX_NEIGHBORS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	bcsd_bond_if.sink          bond_in,
	bcsd_res_if.source         result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);
	localparam int DEPTH = (MAX_BONDS < 65536) ? MAX_BONDS : 65536;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_NEIGHBORS + 1);

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_SQ   = 4'd2;
	localparam logic [3:0] ST_ROOT = 4'd3;
	localparam logic [3:0] ST_MUL0 = 4'd4;
	localparam logic [3:0] ST_MUL1 = 4'd5;
	localparam logic [3:0] ST_CMP  = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	logic [4:0] cnt_q;
	logic [AW-1:0] clr_addr_q;

	logic [CS_W-1:0] crit_q;
	logic            therm_en_q;
	logic [TC_W-1:0] therm_coef_q;

	logic signed [FIELD_W-1:0] rx_q, ry_q, rz_q, cx_q, cy_q, cz_q, dt_q;
	logic [SLOT_W-1:0] slot_sh_q;
	logic [SLOT_W-1:0] slot_rem_q;
	logic last_q;
	logic empty_q;

	logic [SQ_W-1:0] ss0_q, ss1_q;
	logic signed [K_W-1:0] k_q;
	logic [LEN_W-1:0] l0, l1;
	logic [K_LO_W+LEN_W-1:0] plo_q;
	logic signed [PROD_W-1:0] prod_q;

	logic [CW-1:0] bond_cnt_q, broke_cnt_q;
	logic [CW:0]   div_rem_q;
	logic [DMG_W-1:0] quo_q;
	logic bb_q, nb_q;

	logic out_valid_q, out_bb_q, out_nb_q, out_done_q;
	logic [DMG_W-1:0] out_dmg_q;

	// store access
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_rdata;

	// squaring
	logic signed [FIELD_W-1:0] sel_r, sel_c;
	logic [FIELD_W-1:0] mag_r, mag_c;
	logic [SQ_W-1:0] sq_r, sq_c, sum_r, sum_c;
	sqrt_ctl_t sqrt_ctl;

	logic signed [K_W-1:0] k_next;
	logic [SLOT_W:0] slot_r;
	logic signed [PROD_W-1:0] rhs_next;
	logic signed [PROD_W-1:0] lhs;
	logic signed [LEN_W:0] dlen;
	logic trial, now;
	logic [CW:0] div_r;
	logic div_bit;
	logic cfg_wr;
	logic out_free;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    begin sel_r = rx_q; sel_c = cx_q; end
			2'd1:    begin sel_r = ry_q; sel_c = cy_q; end
			default: begin sel_r = rz_q; sel_c = cz_q; end
		endcase
		mag_r = sel_r[FIELD_W-1] ? FIELD_W'(-sel_r) : FIELD_W'(sel_r);
		mag_c = sel_c[FIELD_W-1] ? FIELD_W'(-sel_c) : FIELD_W'(sel_c);
		sq_r  = SQ_W'(mag_r) * SQ_W'(mag_r);
		sq_c  = SQ_W'(mag_c) * SQ_W'(mag_c);
		sum_r = ss0_q + sq_r;
		sum_c = ss1_q + sq_c;
		sqrt_ctl.load = (state_q == ST_SQ) && (cnt_q == 5'd2);
		sqrt_ctl.step = (state_q == ST_ROOT);
	end

	bcsd_sqrt u_sqrt_ref (.clk(clk), .ctl(sqrt_ctl), .radicand(sum_r), .root(l0));
	bcsd_sqrt u_sqrt_cur (.clk(clk), .ctl(sqrt_ctl), .radicand(sum_c), .root(l1));

	always_comb begin
		k_next = K_W'({1'b0, crit_q, 16'h0000});
		if (therm_en_q) begin
			k_next = k_next + K_W'($signed(therm_coef_q) * dt_q);
		end
		slot_r   = {slot_rem_q, slot_sh_q[SLOT_W-1]};
		rhs_next = (PROD_W'($signed({1'b0, l0}) * $signed(k_q[K_W-1:K_LO_W])) <<< K_LO_W)
			+ PROD_W'(plo_q);
		dlen  = $signed({1'b0, l1}) - $signed({1'b0, l0});
		lhs   = PROD_W'(dlen) <<< 40;
		trial = (l0 != '0) && (lhs > prod_q);
		now   = ram_rdata | trial;
		div_r = (cnt_q == 5'd0) ? {1'b0, broke_cnt_q} : {div_rem_q[CW-1:0], 1'b0};
		div_bit = div_r >= {1'b0, bond_cnt_q};
	end

	always_comb begin
		if (state_q == ST_CLR) begin
			ram_we = 1'b1; ram_waddr = clr_addr_q; ram_wdata = 1'b0;
		end else begin
			ram_we = (state_q == ST_CMP); ram_waddr = slot_rem_q[AW-1:0]; ram_wdata = now;
		end
	end

	bcsd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(slot_rem_q[AW-1:0]), .rdata(ram_rdata)
	);

	assign out_free       = !out_valid_q || result.ready;
	assign bond_in.ready  = (state_q == ST_IDLE);
	assign cfg_wr         = psel && penable && pwrite;
	assign pready         = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_CRIT_STRETCH: prdata = DATA_W'(crit_q);
			REG_THERM_EN:     prdata = DATA_W'(therm_en_q);
			REG_THERM_COEF:   prdata = therm_coef_q;
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q       <= '1;
			therm_en_q   <= 1'b0;
			therm_coef_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CRIT_STRETCH: crit_q <= pwdata[CS_W-1:0];
				REG_THERM_EN:     therm_en_q <= pwdata[0];
				REG_THERM_COEF:   therm_coef_q <= pwdata;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bond_in.valid && bond_in.ready) begin
			rx_q <= bond_in.ref_dx; ry_q <= bond_in.ref_dy; rz_q <= bond_in.ref_dz;
			cx_q <= bond_in.cur_dx; cy_q <= bond_in.cur_dy; cz_q <= bond_in.cur_dz;
			dt_q <= bond_in.temp_change;
			slot_sh_q <= bond_in.bond_slot;
			last_q  <= bond_in.node_last;
			empty_q <= bond_in.node_empty;
			ss0_q <= '0;
			ss1_q <= '0;
			slot_rem_q <= '0;
		end
		if (state_q == ST_SQ) begin
			ss0_q <= sum_r;
			ss1_q <= sum_c;
			if (cnt_q == 5'd0) begin
				k_q <= k_next;
			end
		end
		// slot modulo the store depth, one slot bit per step
		if (state_q == ST_ROOT && cnt_q < 5'd16) begin
			slot_sh_q <= {slot_sh_q[SLOT_W-2:0], 1'b0};
			if (slot_r >= (SLOT_W+1)'(DEPTH)) begin
				slot_rem_q <= SLOT_W'(slot_r - (SLOT_W+1)'(DEPTH));
			end else begin
				slot_rem_q <= slot_r[SLOT_W-1:0];
			end
		end
		if (state_q == ST_MUL0) begin
			plo_q <= l0 * k_q[K_LO_W-1:0];
		end
		if (state_q == ST_MUL1) begin
			prod_q <= rhs_next;
		end
		if (state_q == ST_CMP) begin
			bb_q <= now;
			nb_q <= now && !ram_rdata;
		end
		if (state_q == ST_DIV) begin
			div_rem_q <= div_bit ? (CW+1)'(div_r - {1'b0, bond_cnt_q}) : div_r;
			quo_q     <= {quo_q[DMG_W-2:0], div_bit};
		end
		if (state_q == ST_OUT && out_free) begin
			out_bb_q   <= empty_q ? 1'b0 : bb_q;
			out_nb_q   <= empty_q ? 1'b0 : nb_q;
			out_done_q <= empty_q || last_q;
			out_dmg_q  <= (empty_q || !last_q || bond_cnt_q == '0) ? '0 : quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cnt_q       <= '0;
			clr_addr_q  <= '0;
			bond_cnt_q  <= '0;
			broke_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (bond_in.valid) begin
						state_q <= bond_in.node_empty ? ST_OUT : ST_SQ;
					end
				end
				ST_SQ: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ROOT: begin
					if (cnt_q == 5'(LEN_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_CMP;
				ST_CMP: begin
					if (bond_cnt_q < CW'(MAX_NEIGHBORS)) begin
						bond_cnt_q <= bond_cnt_q + 1'b1;
						if (now) begin
							broke_cnt_q <= broke_cnt_q + 1'b1;
						end
					end else if (now && broke_cnt_q < CW'(MAX_NEIGHBORS)) begin
						broke_cnt_q <= broke_cnt_q + 1'b1;
					end
					cnt_q   <= '0;
					state_q <= last_q ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(DMG_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						if (empty_q || last_q) begin
							bond_cnt_q  <= '0;
							broke_cnt_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.bond_broken  = out_bb_q;
	assign result.newly_broken = out_nb_q;
	assign result.node_done    = out_done_q;
	assign result.node_damage  = out_dmg_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLR |-> !bond_in.ready) else $error("bond taken during clear");
	a_new_implies_broken: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.newly_broken |-> result.bond_broken)
		else $error("newly broken bond not marked broken");
	a_damage_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.node_damage <= 16'd32768)
		else $error("damage above one");
	a_damage_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.node_done |-> result.node_damage == '0)
		else $error("damage without node end");
	a_counts_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> broke_cnt_q <= bond_cnt_q)
		else $error("broken count above bond count");
endmodule

// ===== verif/tb_bond_critical_stretch_damage_unit.sv =====
`timescale 1ns / 1ps

module tb_bond_critical_stretch_damage_unit;
	import bcsd_pkg::*;

	localparam int STORE_DEPTH = 65536;
	localparam int NODE_SAT    = 1024;
	localparam int DRAIN_WAIT  = 60;

	typedef struct {
		logic signed [FIELD_W-1:0] ref_dx, ref_dy, ref_dz;
		logic signed [FIELD_W-1:0] cur_dx, cur_dy, cur_dz;
		logic signed [FIELD_W-1:0] temp_change;
		logic [SLOT_W-1:0]         bond_slot;
		logic                      node_last;
		logic                      node_empty;
	} bond_t;

	typedef struct {
		logic              bond_broken;
		logic              newly_broken;
		logic              node_done;
		logic [DMG_W-1:0]  node_damage;
	} damage_t;

	typedef struct {
		bond_t   bond;
		logic    typed;
		damage_t known;
	} bond_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	bcsd_bond_if bond_if();
	bcsd_res_if  res_if();

	bond_critical_stretch_damage_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bond_in (bond_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	bit               broken_mark [STORE_DEPTH];
	int unsigned      node_broken;
	int unsigned      node_bonds;
	logic [CS_W-1:0]  crit_stretch;
	logic             therm_en;
	logic [TC_W-1:0]  therm_coef;

	damage_t pending_damage[$];
	int      fail_count;
	int      snd_idle_pct;
	int      rcv_idle_pct;
	int      rcv_hold_cycles;

	always #5 clk = ~clk;

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned bond_length(logic signed [FIELD_W-1:0] x,
			logic signed [FIELD_W-1:0] y, logic signed [FIELD_W-1:0] z);
		longint sx, sy, sz;
		sx = x;
		sy = y;
		sz = z;
		return floor_sqrt(longint'(sx * sx + sy * sy + sz * sz));
	endfunction

	// advance the model state by one bond and return what the block should report
	function automatic damage_t bond_damage_step(bond_t b);
		damage_t r;
		longint unsigned l0, l1;
		logic signed [127:0] lhs, rhs, thr, coef, dt;
		bit old_mark, trial, now_mark;
		r = '{default: 0};
		if (b.node_empty) begin
			node_broken = 0;
			node_bonds = 0;
			r.node_done = 1;
			return r;
		end
		l0 = bond_length(b.ref_dx, b.ref_dy, b.ref_dz);
		l1 = bond_length(b.cur_dx, b.cur_dy, b.cur_dz);
		thr = {104'd0, crit_stretch};
		thr = thr <<< 16;
		if (therm_en) begin
			coef = $signed(therm_coef);
			dt = b.temp_change;
			thr = thr + coef * dt;
		end
		lhs = longint'(l1) - longint'(l0);
		lhs = lhs <<< 40;
		rhs = {64'd0, l0};
		rhs = rhs * thr;
		trial = (l0 != 0) && (lhs > rhs);
		old_mark = broken_mark[b.bond_slot];
		now_mark = old_mark || trial;
		broken_mark[b.bond_slot] = now_mark;
		if (node_bonds < NODE_SAT) begin
			node_bonds++;
			if (now_mark)
				node_broken++;
		end else if (now_mark && node_broken < NODE_SAT) begin
			node_broken++;
		end
		r.bond_broken = now_mark;
		r.newly_broken = now_mark && !old_mark;
		if (b.node_last) begin
			r.node_done = 1;
			r.node_damage = (node_bonds != 0) ? DMG_W'((node_broken * 32768) / node_bonds) : 0;
			node_broken = 0;
			node_bonds = 0;
		end
		return r;
	endfunction

	function automatic bond_t mk_bond(int rx, int ry, int rz, int cx, int cy, int cz,
			int tc, int slot, bit last, bit empty);
		bond_t b;
		b.ref_dx = rx;  b.ref_dy = ry;  b.ref_dz = rz;
		b.cur_dx = cx;  b.cur_dy = cy;  b.cur_dz = cz;
		b.temp_change = tc;
		b.bond_slot = slot;
		b.node_last = last;
		b.node_empty = empty;
		return b;
	endfunction

	function automatic int clip24(longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return int'(v);
	endfunction

	function automatic int rand_comp();
		if ($urandom_range(0, 3) == 0)
			return int'($signed(24'($urandom)));
		return int'($urandom_range(0, 1 << 18)) - (1 << 17);
	endfunction

	// current vector: copy, random, or reference shrunk or stretched by a random power-of-two fraction
	function automatic bond_t rand_bond(bit last);
		bond_t b;
		int r[3], c[3];
		int sh, mode, tc, slot;
		mode = $urandom_range(0, 4);
		sh = $urandom_range(0, 10);
		for (int i = 0; i < 3; i++) begin
			r[i] = rand_comp();
			case (mode)
				0: c[i] = r[i];
				1: c[i] = rand_comp();
				2: c[i] = clip24(longint'(r[i]) - (r[i] >>> sh));
				default: c[i] = clip24(longint'(r[i]) + (r[i] >>> sh) + $urandom_range(0, 3));
			endcase
		end
		if ($urandom_range(0, 19) == 0)
			r = '{0, 0, 0};
		tc = $urandom_range(0, 1) ? int'($signed(24'($urandom))) : int'($urandom_range(0, 4096)) - 2048;
		slot = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 127) : $urandom_range(0, 65535);
		b = mk_bond(r[0], r[1], r[2], c[0], c[1], c[2], tc, slot, last, 0);
		if ($urandom_range(0, 39) == 0)
			b.node_empty = 1;
		return b;
	endfunction

	task automatic push_bond(bond_t b, logic typed, damage_t known);
		damage_t predicted;
		int gap;
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			gap = $urandom_range(1, 4);
			bond_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		bond_if.valid <= 1;
		bond_if.ref_dx <= b.ref_dx;
		bond_if.ref_dy <= b.ref_dy;
		bond_if.ref_dz <= b.ref_dz;
		bond_if.cur_dx <= b.cur_dx;
		bond_if.cur_dy <= b.cur_dy;
		bond_if.cur_dz <= b.cur_dz;
		bond_if.temp_change <= b.temp_change;
		bond_if.bond_slot <= b.bond_slot;
		bond_if.node_last <= b.node_last;
		bond_if.node_empty <= b.node_empty;
		do
			@(posedge clk);
		while (!bond_if.ready);
		predicted = bond_damage_step(b);
		pending_damage.insert(pending_damage.size(), typed ? known : predicted);
	endtask

	task automatic push_random_node(int len);
		damage_t none;
		none = '{default: 0};
		if (len == 0)
			push_bond(mk_bond(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, none);
		for (int i = 0; i < len; i++)
			push_bond(rand_bond(i == len - 1), 0, none);
	endtask

	task automatic drain();
		bond_if.valid <= 0;
		wait (pending_damage.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_CRIT_STRETCH: crit_stretch = value[CS_W-1:0];
			REG_THERM_EN:     therm_en = value[0];
			REG_THERM_COEF:   therm_coef = value[TC_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [CS_W-1:0] cs, logic te, logic [TC_W-1:0] tcoef);
		reg_write(REG_CRIT_STRETCH, DATA_W'(cs));
		reg_write(REG_THERM_EN, DATA_W'(te));
		reg_write(REG_THERM_COEF, tcoef);
	endtask

	task automatic run_phase(int n_items, int hold_at, bit pause_mid);
		int sent, len;
		sent = 0;
		while (sent < n_items) begin
			if (hold_at >= 0 && sent >= hold_at && hold_at + 8 > sent)
				rcv_hold_cycles = 400;
			if (pause_mid && sent >= n_items / 2 && sent < n_items / 2 + 6) begin
				bond_if.valid <= 0;
				wait (pending_damage.size() == 0);
				@(posedge clk);
			end
			len = $urandom_range(0, 7);
			push_random_node(len);
			sent += (len == 0) ? 1 : len;
		end
		drain();
	endtask

	always @(posedge clk) begin
		damage_t exp_d;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_damage.size() == 0) begin
				$error("result with no bond outstanding");
				fail_count++;
			end else begin
				exp_d = pending_damage.pop_front();
				if (res_if.bond_broken !== exp_d.bond_broken) begin
					$error("bond_broken: expected %0d, got %0d", exp_d.bond_broken,
						res_if.bond_broken);
					fail_count++;
				end
				if (res_if.newly_broken !== exp_d.newly_broken) begin
					$error("newly_broken: expected %0d, got %0d", exp_d.newly_broken,
						res_if.newly_broken);
					fail_count++;
				end
				if (res_if.node_done !== exp_d.node_done) begin
					$error("node_done: expected %0d, got %0d", exp_d.node_done,
						res_if.node_done);
					fail_count++;
				end
				if (res_if.node_damage !== exp_d.node_damage) begin
					$error("node_damage: expected %0d, got %0d", exp_d.node_damage,
						res_if.node_damage);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		res_if.ready <= 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rcv_hold_cycles > 0) begin
				res_if.ready <= 0;
				rcv_hold_cycles--;
			end else begin
				res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	initial begin
		bond_row_t rows[$];
		damage_t none;
		none = '{default: 0};
		clk = 0;
		arst_n <= 0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		bond_if.valid <= 0;
		bond_if.ref_dx <= '0;
		bond_if.ref_dy <= '0;
		bond_if.ref_dz <= '0;
		bond_if.cur_dx <= '0;
		bond_if.cur_dy <= '0;
		bond_if.cur_dz <= '0;
		bond_if.temp_change <= '0;
		bond_if.bond_slot <= '0;
		bond_if.node_last <= 0;
		bond_if.node_empty <= 0;
		fail_count = 0;
		rcv_hold_cycles = 0;
		snd_idle_pct = 19;
		rcv_idle_pct = 74;
		node_broken = 0;
		node_bonds = 0;
		crit_stretch = 24'hFFFFFF;
		therm_en = 0;
		therm_coef = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		rows.insert(rows.size(), '{mk_bond(0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, '{0, 0, 1, 0}});
		rows.insert(rows.size(), '{mk_bond(65536, 0, 0, 8388607, 0, 0, 0, 5, 1, 0), 1,
			'{1, 1, 1, 32768}});
		rows.insert(rows.size(), '{mk_bond(65536, 0, 0, 65536, 0, 0, 0, 5, 1, 0), 1,
			'{1, 0, 1, 32768}});
		rows.insert(rows.size(), '{mk_bond(-8388608, -8388608, -8388608, 0, 0, 0, 0, 6, 1, 0),
			1, '{0, 0, 1, 0}});
		rows.insert(rows.size(), '{mk_bond(0, 0, 0, 8388607, 8388607, 8388607, 0, 7, 1, 0), 1,
			'{0, 0, 1, 0}});
		rows.insert(rows.size(), '{mk_bond(8388607, 8388607, 8388607, -8388608, -8388608,
			-8388608, 8388607, 65535, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk_bond(1, -1, 1, 8388607, -8388608, 8388607, -8388608,
			32768, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk_bond(65536, 65536, 0, 300000, 0, 0, 1234, 21845, 1, 0),
			0, none});
		// open a node, then discard it with an empty node
		rows.insert(rows.size(), '{mk_bond(65536, 0, 0, 8388607, 0, 0, 0, 9, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk_bond(-1, -1, -1, -1, -1, -1, -1, 65535, 1, 1), 1,
			'{0, 0, 1, 0}});
		rows.insert(rows.size(), '{mk_bond(65536, 0, 0, 65536, 0, 0, 0, 9, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk_bond(0, 65536, 0, 0, 8388607, 0, 0, 10, 0, 0), 0, none});
		rows.insert(rows.size(), '{mk_bond(0, 0, 65536, 0, 0, 65537, 0, 11, 1, 0), 0, none});
		foreach (rows[i])
			push_bond(rows[i].bond, rows[i].typed, rows[i].known);
		drain();

		set_regs(24'h100000, 0, 0);
		run_phase(150, 60, 0);
		set_regs(24'h000000, 1, 32'h80000000);
		run_phase(100, -1, 0);

		snd_idle_pct = 74;
		rcv_idle_pct = 19;
		set_regs(24'h400000, 1, 32'h7FFFFFFF);
		run_phase(150, -1, 1);
		set_regs(24'hFFFFFF, 1, $urandom);
		run_phase(100, -1, 0);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_regs(24'($urandom_range(0, 24'hFFFFFF)), 0, $urandom);
		run_phase(250, -1, 0);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
